>>> hdl/sha256_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the round-constant table for the SHA-256 engine.
// Used by sha256_ctrl, sha256_dp and sha256_hash; depends on nothing else.
package sha256_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_UPDATE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } t_state;

    // Source of a byte pushed into the block window.
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;
        t_src       src;
        logic       load;
        logic       round;
        logic       update;
        logic       init;
        logic [5:0] round_idx;
        logic [2:0] word_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
    } t_status;

    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;
    localparam logic [7:0] PAD_MARK     = 8'h80;

    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constant for round t.
    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/sha256_dp.sv
`timescale 1ns / 1ps
// Datapath of the SHA-256 engine: 64-byte block window, message schedule,
// round logic, chaining words and byte counters. Depends on sha256_pkg.
module sha256_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_cmd     i_cmd,
    input  logic [7:0]           i_data_byte,
    output sha256_pkg::t_status  o_status,
    output logic [31:0]          o_digest_word
);
    import sha256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Block window: byte 0 of the block ends up in the top bits. During
    // compression it doubles as the 16-word schedule window.
    logic [511:0] r_win, n_win;
    logic [31:0]  r_chain [8];
    logic [31:0]  r_v [8];
    logic [5:0]   r_fill;
    logic [60:0]  r_total;
    logic [7:0]   s_byte;
    logic [63:0]  s_bits;
    logic [31:0]  s_w0, s_w1, s_w9, s_w14, s_wnew;
    logic [31:0]  s_t1, s_t2, s_sig0, s_sig1, s_ch, s_maj;

    assign s_bits = {r_total, 3'b000};
    assign s_w0   = r_win[511:480];
    assign s_w1   = r_win[479:448];
    assign s_w9   = r_win[223:192];
    assign s_w14  = r_win[63:32];

    // Byte selection for a push; length bytes go out most significant first.
    always_comb begin
        case (i_cmd.src)
            SRC_DATA: s_byte = i_data_byte;
            SRC_MARK: s_byte = PAD_MARK;
            SRC_LEN:  s_byte = 8'(s_bits >> {~r_fill[2:0], 3'b000});
            default:  s_byte = 8'h00;
        endcase
    end

    // Next schedule word and the round function.
    always_comb begin
        s_wnew = (rotr(s_w14, 17) ^ rotr(s_w14, 19) ^ (s_w14 >> 10)) + s_w9
               + (rotr(s_w1, 7) ^ rotr(s_w1, 18) ^ (s_w1 >> 3)) + s_w0;
        s_sig1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        s_sig0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        s_ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        s_maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        s_t1   = r_v[7] + s_sig1 + s_ch + round_k(i_cmd.round_idx) + s_w0;
        s_t2   = s_sig0 + s_maj;
    end

    // Window shifts by a byte on a push and by a word on a round.
    always_comb begin
        n_win = r_win;
        if (i_cmd.push) begin
            n_win = {r_win[503:0], s_byte};
        end else if (i_cmd.round) begin
            n_win = {r_win[479:0], s_wnew};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + s_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= s_t1 + s_t2;
        end
    end

    // Chaining words and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= INIT_HASH[i];
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.update) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
            end
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
                if (i_cmd.src == SRC_DATA) begin
                    r_total <= r_total + 61'd1;
                end
            end
        end
    end

    assign o_status.fill = r_fill;
    assign o_digest_word = r_chain[i_cmd.word_sel];

endmodule

>>> hdl/sha256_ctrl.sv
`timescale 1ns / 1ps
// Controller of the SHA-256 engine: sequences byte intake, padding, the 64
// rounds, the chaining update and digest output. Depends on sha256_pkg.
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_has_byte,
    input  logic                 i_finish,
    input  logic                 i_out_stall,
    input  sha256_pkg::t_status  i_status,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word,
    output sha256_pkg::t_cmd     o_cmd
);
    import sha256_pkg::*;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       s_full;

    assign s_full = (i_status.fill == FILL_LAST);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands. A push that fills the block starts a
    // compression at once; r_ret holds where to go after it.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_cmd.src   = SRC_DATA;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.push = 1'b1;
                    end
                    if (i_has_byte && s_full) begin
                        o_cmd.load = 1'b1;
                        n_round    = '0;
                        n_state    = ST_COMPRESS;
                        n_ret      = i_finish ? ST_PAD_MARK : ST_IDLE;
                    end else if (i_finish) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_COMPRESS: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = r_ret;
            end
            ST_PAD_MARK: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_MARK;
                n_state    = ST_PAD_ZERO;
                if (s_full) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = ST_COMPRESS;
                    n_ret      = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (i_status.fill == FILL_LEN_POS) begin
                    n_state = ST_PAD_LEN;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_ZERO;
                    if (s_full) begin
                        o_cmd.load = 1'b1;
                        n_round    = '0;
                        n_state    = ST_COMPRESS;
                        n_ret      = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_LEN;
                if (s_full) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = ST_COMPRESS;
                    n_ret      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_idx == WORD_LAST) begin
                        o_cmd.init = 1'b1;
                        n_idx      = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_cmd.round_idx = r_round;
        o_cmd.word_sel  = r_idx;
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == WORD_LAST);

endmodule

>>> hdl/sha256_hash.sv
`timescale 1ns / 1ps
// SHA-256 hash engine, top level: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
// Input channel (i_in_valid / o_in_stall): each request may carry one message
// byte (i_has_byte) and may ask to finish (i_finish). A byte that does not
// complete a 64-byte block is taken without a stall. The byte that completes a
// block starts a compression: 64 rounds, one per cycle in the round unit,
// then the chaining update. o_in_stall is high for the whole of that time.
// On finish the block appends 0x80, zero padding and the 64-bit bit length
// one byte per cycle between compressions, compressing once or twice, before
// the first digest word is offered.
// Output channel (o_out_valid / i_out_stall): eight requests carry the digest
// words, word 0 first, o_last_word set on word 7. A stalled word holds, and
// no new input is taken until all eight are gone; then the chaining words
// return to the initial hash values and the byte counters clear.
// Reset (synchronous, active low) loads the initial hash values, clears the
// counters and leaves the block idle and ready for input.
module sha256_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_finish,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    // Sequencer.
    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_has_byte   (i_has_byte),
        .i_finish     (i_finish),
        .i_out_stall  (i_out_stall),
        .i_status     (s_status),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (s_cmd)
    );

    // Hash datapath.
    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (s_status),
        .o_digest_word (o_digest_word)
    );

    // Input is never taken while digest words are pending.
    a_no_input_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while digest is being delivered");

    // The last word ends the digest.
    a_last_ends_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> !o_out_valid)
        else $error("output continued after last digest word");

    // Words go out in order.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_word) |=>
        (o_out_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word index out of order");

    // The last flag marks word seven only.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == WORD_LAST)))
        else $error("last flag does not match word index");

endmodule

>>> tb/sha256_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the SHA-256 engine: watches both channels, predicts each digest
// and compares every output word field by field. Depends on nothing but its ports.
module sha256_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_finish,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);

    // One expected digest word with its position.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Shadow copy of the engine state.
    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    int           block_fill;
    logic [60:0]  msg_len;

    t_digest_word digest_queue [$];
    int           fail_total = 0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Back to the initial hash values with an empty message.
    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV_WORDS[i];
        block_fill = 0;
        msg_len = '0;
    endtask

    // Fold the 64-byte block into the chaining words.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // Take one request: append its byte, and on finish pad and queue the digest.
    task automatic absorb_request(input logic [7:0] data, input logic has, input logic fin);
        logic [63:0]  bit_len;
        t_digest_word entry;
        if (has) begin
            msg_block[block_fill] = data;
            block_fill++;
            msg_len = msg_len + 61'd1;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (fin) begin
            bit_len = {msg_len, 3'b000};
            msg_block[block_fill] = 8'h80;
            block_fill++;
            // No room for the length: pad out this block and start another.
            if (block_fill > 56) begin
                for (int i = block_fill; i < 64; i++)
                    msg_block[i] = 8'h00;
                compress_block();
                block_fill = 0;
            end
            for (int i = block_fill; i < 56; i++)
                msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = bit_len[8*(7-i) +: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                entry.word  = hash_state[i];
                entry.index = 3'(i);
                entry.last  = (i == 7);
                digest_queue.push_back(entry);
            end
            restart_message();
        end
    endtask

    initial begin
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        restart_message();
    end

    // Sample both channels at each edge; inputs first, then outputs.
    always @(posedge i_clk) begin
        t_digest_word want;
        if (!i_rst_n) begin
            restart_message();
            digest_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                absorb_request(i_data_byte, i_has_byte, i_finish);
            if (i_out_valid && !i_out_stall) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest word %h at index %0d", i_digest_word,
                           i_word_index);
                    fail_total++;
                end else begin
                    want = digest_queue.pop_front();
                    if (i_digest_word !== want.word) begin
                        $error("digest_word: expected %h, actual %h", want.word,
                               i_digest_word);
                        fail_total++;
                    end
                    if (i_word_index !== want.index) begin
                        $error("word_index: expected %0d, actual %0d", want.index,
                               i_word_index);
                        fail_total++;
                    end
                    if (i_last_word !== want.last) begin
                        $error("last_word: expected %0b, actual %0b", want.last,
                               i_last_word);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= digest_queue.size();
    end

endmodule

>>> tb/tb_sha256_hash.sv
`timescale 1ns / 1ps
// Top of the SHA-256 engine testbench: clock, reset, message stimulus and verdict.
// Depends on sha256_hash and on sha256_checker, which predicts and compares.
module tb_sha256_hash;

    localparam int ITEM_TARGET = 310;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 38;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_finish = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int   fail_count;
    int   pending_words;
    int   item_count = 0;
    logic quiet = 1'b0;
    logic hold_off = 1'b0;
    logic hold_go = 1'b0;

    sha256_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_finish      (i_finish),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    sha256_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_finish      (i_finish),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_digest_word (o_digest_word),
        .i_word_index  (o_word_index),
        .i_last_word   (o_last_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Digest receiver: random stalls, none in the quiet stretch, solid during hold-off.
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_stall <= 1'b1;
        else if (quiet)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Long receiver hold-off so the engine fills up and stalls its input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** sha256_hash: FAILED **");
        $finish;
    end

    // Offer one request, after a random gap, and wait until it is taken.
    task automatic send_request(input logic [7:0] data, input logic has, input logic fin);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_has_byte  <= has;
        i_finish    <= fin;
        do @(posedge i_clk); while (o_in_stall);
        if (has || fin)
            item_count++;
    endtask

    // A random message of len bytes; the last byte may ride on the finish request.
    task automatic send_message(input int len);
        logic on_finish;
        int   body;
        on_finish = (len > 0) && ($urandom_range(0, 1) == 1);
        body = on_finish ? len - 1 : len;
        for (int i = 0; i < body; i++) begin
            // Occasional request with no byte, which the engine must ignore.
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, 1'b0);
        end
        send_request(8'($urandom), on_finish, 1'b1);
    endtask

    initial begin
        int lens [4];
        int pick;
        int tmp;
        lens = '{55, 56, 63, 64};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, ignored requests, extreme bytes, back-to-back finishes.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h5a, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);

        // Lengths around the padding boundaries, in random order.
        for (int i = 3; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = lens[i];
            lens[i] = lens[pick];
            lens[pick] = tmp;
        end
        quiet <= 1'b1;
        send_message(lens[0]);
        quiet <= 1'b0;
        hold_go = 1'b1;
        for (int i = 1; i < 4; i++)
            send_message(lens[i]);

        // Short random messages for the rest.
        while (item_count < ITEM_TARGET)
            send_message($urandom_range(0, 20));
        i_in_valid <= 1'b0;

        // Let the checker count the last digest before waiting on it.
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** sha256_hash: PASSED **");
        else
            $display("** sha256_hash: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hdl/sha256_pkg.sv
hdl/sha256_dp.sv
hdl/sha256_ctrl.sv
hdl/sha256_hash.sv
tb/sha256_checker.sv
tb/tb_sha256_hash.sv
